// File: rtl/srpq_pkg.sv
`timescale 1ns / 1ps

package srpq_pkg;

    localparam int DEPTH = 16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [15:0] payload;
        logic [7:0]  priority_req;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_payload;
        logic [7:0]  out_priority;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] payload;
        logic [7:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t entry;
    } cell_cmd_t;

endpackage

// File: rtl/sorted_ring_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue of srpq_pkg::DEPTH entries (16), built as a row of cells that
// holds the entries in ascending priority from cell 0, equal priorities in arrival
// order. Each transfer on s_ is one operation and gives exactly one result on m_ in
// the following cycle: an enqueue is placed by every cell comparing against the new
// priority and shifting back in parallel, and a dequeue shifts every cell one
// place forward. One operation is taken per cycle while m_ is drained; the output
// register alone sets back-pressure. An enqueue into a queue holding DEPTH entries
// returns status full and changes nothing; a dequeue from an empty queue returns
// status empty with zero payload and priority.
module sorted_ring_priority_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  srpq_pkg::in_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output srpq_pkg::out_t m_data
);

    srpq_pkg::entry_t    cell_entry [srpq_pkg::DEPTH];
    logic                cell_displaced [srpq_pkg::DEPTH];
    srpq_pkg::cell_cmd_t cmd;

    logic           accept;
    logic           full;
    logic           empty;
    srpq_pkg::out_t result;

    logic           m_valid_reg;
    logic           m_valid_next;
    srpq_pkg::out_t m_data_reg;
    srpq_pkg::out_t m_data_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = cell_entry[srpq_pkg::DEPTH-1].valid;
    assign empty   = !cell_entry[0].valid;

    always_comb begin
        cmd.enq           = accept && (s_data.operation == srpq_pkg::OP_ENQ) && !full;
        cmd.deq           = accept && (s_data.operation == srpq_pkg::OP_DEQ) && !empty;
        cmd.entry.valid   = 1'b1;
        cmd.entry.payload = s_data.payload;
        cmd.entry.prio    = s_data.priority_req;
    end

    for (genvar i = 0; i < srpq_pkg::DEPTH; i++) begin : g_cell
        srpq_pkg::entry_t left_entry;
        srpq_pkg::entry_t right_entry;
        logic             left_displaced;

        if (i == 0) begin : g_first
            assign left_entry     = '0;
            assign left_displaced = 1'b0;
        end else begin : g_mid
            assign left_entry     = cell_entry[i-1];
            assign left_displaced = cell_displaced[i-1];
        end

        if (i == srpq_pkg::DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        srpq_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cmd            (cmd),
            .left_entry     (left_entry),
            .left_displaced (left_displaced),
            .right_entry    (right_entry),
            .entry          (cell_entry[i]),
            .displaced      (cell_displaced[i])
        );
    end

    always_comb begin
        result = '0;
        case (s_data.operation)
            srpq_pkg::OP_ENQ: begin
                result.status = full ? srpq_pkg::ST_FULL : srpq_pkg::ST_ADDED;
            end
            srpq_pkg::OP_DEQ: begin
                if (empty) begin
                    result.status = srpq_pkg::ST_EMPTY;
                end else begin
                    result.status       = srpq_pkg::ST_DEQUEUED;
                    result.out_payload  = cell_entry[0].payload;
                    result.out_priority = cell_entry[0].prio;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    assign m_valid_next = accept || (m_valid_reg && !m_ready);
    assign m_data_next  = accept ? result : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/srpq_cell.sv
`timescale 1ns / 1ps

module srpq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  srpq_pkg::cell_cmd_t cmd,
    input  srpq_pkg::entry_t    left_entry,
    input  logic                left_displaced,
    input  srpq_pkg::entry_t    right_entry,
    output srpq_pkg::entry_t    entry,
    output logic                displaced
);

    srpq_pkg::entry_t entry_reg;
    srpq_pkg::entry_t entry_next;

    // new entry goes ahead of this one: empty cell or strictly larger priority
    assign displaced = !entry_reg.valid || (entry_reg.prio > cmd.entry.prio);
    assign entry     = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.deq) begin
            entry_next = right_entry;
        end else if (cmd.enq && displaced) begin
            // left neighbor also moves back, so take its entry
            if (left_displaced) begin
                entry_next = left_entry;
            end else begin
                entry_next       = cmd.entry;
                entry_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: rtl/srpq_checker.sv
`timescale 1ns / 1ps

module srpq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input srpq_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input srpq_pkg::out_t m_data
);

    // every accepted operation shows its result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("srpq: transfer without result");

    // input side is never blocked while the output register is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("srpq: stalled with empty output");

    // only a dequeued item carries payload and priority
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != srpq_pkg::ST_DEQUEUED))
            |-> (m_data.out_payload == 16'd0 && m_data.out_priority == 8'd0))
        else $error("srpq: nonzero fields without dequeue");

    // result waiting on a stall keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("srpq: result changed while stalled");

    // an enqueue answers added or full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.operation == srpq_pkg::OP_ENQ)
            |=> (m_data.status == srpq_pkg::ST_ADDED
                 || m_data.status == srpq_pkg::ST_FULL))
        else $error("srpq: enqueue with wrong status");

endmodule

bind sorted_ring_priority_queue srpq_checker u_srpq_checker (.*);
